@@ design/wmwm_pkg.sv @@
// shared types, codes and defaults for the word multiset window matcher
package wmwm_pkg;

    localparam int MAX_WORDS_DEF    = 16;
    localparam int MAX_WORD_LEN_DEF = 8;
    localparam int TEXT_LEN_DEF     = 65536;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 16;
    localparam int CMD_W    = 2;
    localparam int WLEN_W   = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_CHAR = 2'd1,
        CMD_NEW  = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic cmp;
        logic crd;
        logic cchk;
        logic hrd;
        logic pop;
        logic push;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic go_scan;
        logic hit;
        logic last;
        logic is_load;
        logic cnt_full;
        logic fill_nz;
        logic out_busy;
    } t_sts;

endpackage

@@ design/wmwm_ctrl.sv @@
// sequencing state machine for the word multiset window matcher
module wmwm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  wmwm_pkg::t_sts  i_sts,
    output wmwm_pkg::t_ctl  o_ctl
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_RD   = 8'b0000_0010,
        ST_CMP  = 8'b0000_0100,
        ST_CRD  = 8'b0000_1000,
        ST_CCHK = 8'b0001_0000,
        ST_LOOP = 8'b0010_0000,
        ST_HRD  = 8'b0100_0000,
        ST_ORD  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctl.accept = 1'b1;
                    if (i_sts.go_scan) n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                o_ctl.cmp = 1'b1;
                if (i_sts.hit) begin
                    n_state = i_sts.is_load ? ST_IDLE : ST_CRD;
                end else if (i_sts.last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_CRD: begin
                o_ctl.crd = 1'b1;
                n_state   = ST_CCHK;
            end
            ST_CCHK: begin
                o_ctl.cchk = 1'b1;
                n_state    = ST_LOOP;
            end
            ST_LOOP: begin
                if (i_sts.cnt_full && i_sts.fill_nz) begin
                    n_state = ST_HRD;
                end else if (i_sts.cnt_full) begin
                    n_state = ST_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_ctl.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_HRD: begin
                o_ctl.hrd = 1'b1;
                n_state   = ST_ORD;
            end
            ST_ORD: begin
                o_ctl.pop = 1'b1;
                n_state   = ST_LOOP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE) && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/wmwm_datapath.sv @@
// dictionary, per-phase windows, text tracking and result register
module wmwm_datapath #(
    parameter int MAX_WORDS    = wmwm_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = wmwm_pkg::MAX_WORD_LEN_DEF,
    parameter int TEXT_LEN     = wmwm_pkg::TEXT_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wmwm_pkg::t_ctl                i_ctl,
    output wmwm_pkg::t_sts                o_sts,
    input  logic [wmwm_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic [wmwm_pkg::CMD_W-1:0]    i_s_tuser,
    input  logic                          i_cfg_we,
    input  logic [wmwm_pkg::WLEN_W-1:0]   i_cfg_wdata,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [wmwm_pkg::M_DATA_W-1:0] o_m_tdata
);

    localparam int IW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW     = $clog2(MAX_WORDS + 1);
    localparam int PW     = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int CDEPTH = MAX_WORD_LEN * MAX_WORDS;
    localparam int AW     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int TW     = $clog2(TEXT_LEN + 1);
    localparam int SW     = (TW > 16) ? TW : 16;
    localparam int LW     = wmwm_pkg::WLEN_W;

    function automatic logic [AW-1:0] f_addr(input logic [PW-1:0] ph, input logic [IW-1:0] ix);
        return AW'(ph) * AW'(MAX_WORDS) + AW'(ix);
    endfunction

    // memories
    logic [CW+63:0] r_dict [MAX_WORDS];
    logic [CW+63:0] r_dict_q;
    logic [CW-1:0]  r_cnt_mem [CDEPTH];
    logic [CW-1:0]  r_cq;
    logic           r_cvq;
    logic [IW-1:0]  r_hist [CDEPTH];
    logic [IW-1:0]  r_hist_q;

    // control state
    logic [LW-1:0]  r_wlen;
    logic [CW-1:0]  r_used;
    logic [CW-1:0]  r_total;
    logic [63:0]    r_recent;
    logic [TW-1:0]  r_pos;
    logic [PW-1:0]  r_mod  [MAX_WORD_LEN];
    logic [IW-1:0]  r_head [MAX_WORD_LEN];
    logic [CW-1:0]  r_fill [MAX_WORD_LEN];
    logic           r_cval [CDEPTH];
    logic [PW-1:0]  r_ph;
    logic [IW-1:0]  r_i;
    logic           r_is_load;
    logic           r_ov;

    // payload
    logic [63:0]    r_key;
    logic [IW-1:0]  r_idx;
    logic [CW-1:0]  r_tgt;
    logic [CW-1:0]  r_cnt;
    logic [IW-1:0]  r_old;
    logic [15:0]    r_od;

    wmwm_pkg::t_cmd s_cmd;
    logic [63:0]    s_word;
    logic [7:0]     s_ch;
    logic [LW-1:0]  w_eff;
    logic [63:0]    w_mask;
    logic [63:0]    n_recent;
    logic [63:0]    n_cur;
    logic [TW-1:0]  n_pos;
    logic [PW-1:0]  n_mod [MAX_WORD_LEN];
    logic [PW-1:0]  n_ph;
    logic           load_ok;
    logic           char_ok;
    logic           char_scan;
    logic           hit;
    logic           last;
    logic           dict_we;
    logic [IW-1:0]  dict_wa;
    logic [CW+63:0] dict_wd;
    logic [AW-1:0]  c_raddr;
    logic           c_we;
    logic [AW-1:0]  c_waddr;
    logic [CW-1:0]  c_wdata;
    logic [CW-1:0]  oc;
    logic [CW-1:0]  cur_fill;
    logic [CW-1:0]  n_fill;
    logic [CW:0]    slot_sum;
    logic [IW-1:0]  slot;
    logic [IW-1:0]  cur_head;
    logic [IW-1:0]  n_head;
    logic [SW-1:0]  start_full;

    assign s_cmd  = wmwm_pkg::t_cmd'(i_s_tuser);
    assign s_word = i_s_tdata[63:0];
    assign s_ch   = i_s_tdata[71:64];

    always_comb begin
        if (r_wlen == '0) begin
            w_eff = LW'(1);
        end else if (r_wlen > LW'(MAX_WORD_LEN)) begin
            w_eff = LW'(MAX_WORD_LEN);
        end else begin
            w_eff = r_wlen;
        end
    end

    assign w_mask   = (w_eff >= LW'(8)) ? {64{1'b1}} : ~({64{1'b1}} << (7'(w_eff) * 7'd8));
    assign n_recent = {s_ch, r_recent[63:8]};
    assign n_cur    = n_recent >> (7'd64 - 7'(w_eff) * 7'd8);
    assign n_pos    = r_pos + TW'(1);

    always_comb begin
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            n_mod[k] = (r_mod[k] == PW'(k)) ? '0 : r_mod[k] + PW'(1);
        end
    end

    assign n_ph      = n_mod[PW'(w_eff - LW'(1))];
    assign load_ok   = (r_total < CW'(MAX_WORDS));
    assign char_ok   = (r_pos < TW'(TEXT_LEN));
    assign char_scan = char_ok && (n_pos >= TW'(w_eff)) && (r_total != '0);

    assign hit  = (r_dict_q[63:0] == r_key);
    assign last = ((CW'(r_i) + CW'(1)) >= r_used);

    assign cur_fill = r_fill[r_ph];
    assign cur_head = r_head[r_ph];
    assign n_head   = (cur_head == IW'(MAX_WORDS - 1)) ? '0 : cur_head + IW'(1);
    assign n_fill   = cur_fill + CW'(1);
    assign slot_sum = (CW + 1)'(cur_head) + (CW + 1)'(cur_fill);
    assign slot     = (slot_sum >= (CW + 1)'(MAX_WORDS)) ?
                      IW'(slot_sum - (CW + 1)'(MAX_WORDS)) : IW'(slot_sum);
    assign oc       = r_cvq ? r_cq : '0;
    assign start_full = SW'(r_pos) - SW'(w_eff) * SW'(n_fill);

    always_comb begin
        o_sts.go_scan  = 1'b0;
        case (s_cmd)
            wmwm_pkg::CMD_LOAD: o_sts.go_scan = load_ok && (r_used != '0);
            wmwm_pkg::CMD_CHAR: o_sts.go_scan = char_scan;
            default:            o_sts.go_scan = 1'b0;
        endcase
        o_sts.hit      = hit;
        o_sts.last     = last;
        o_sts.is_load  = r_is_load;
        o_sts.cnt_full = (r_cnt >= r_tgt);
        o_sts.fill_nz  = (cur_fill != '0);
        o_sts.out_busy = r_ov && !i_m_tready;
    end

    // dictionary write port
    always_comb begin
        dict_we = 1'b0;
        dict_wa = IW'(r_used);
        dict_wd = {CW'(1), r_key};
        if (i_ctl.accept && s_cmd == wmwm_pkg::CMD_LOAD && load_ok && r_used == '0) begin
            dict_we = 1'b1;
            dict_wd = {CW'(1), s_word & w_mask};
        end else if (i_ctl.cmp && r_is_load) begin
            if (hit) begin
                dict_we = 1'b1;
                dict_wa = r_i;
                dict_wd = {r_dict_q[CW+63:64] + CW'(1), r_dict_q[63:0]};
            end else if (last) begin
                dict_we = 1'b1;
            end
        end
    end

    // count write port
    always_comb begin
        c_raddr = i_ctl.hrd ? f_addr(r_ph, r_hist_q) : f_addr(r_ph, r_idx);
        c_we    = 1'b0;
        c_waddr = f_addr(r_ph, r_idx);
        c_wdata = r_cnt + CW'(1);
        if (i_ctl.pop) begin
            c_we    = (oc != '0);
            c_waddr = f_addr(r_ph, r_old);
            c_wdata = oc - CW'(1);
        end else if (i_ctl.push) begin
            c_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dict_q <= r_dict[r_i];
        if (dict_we) r_dict[dict_wa] <= dict_wd;
    end

    always_ff @(posedge i_clk) begin
        r_cq <= r_cnt_mem[c_raddr];
        if (c_we) r_cnt_mem[c_waddr] <= c_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_hist_q <= r_hist[f_addr(r_ph, cur_head)];
        if (i_ctl.push) r_hist[f_addr(r_ph, slot)] <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen    <= LW'(1);
            r_used    <= '0;
            r_total   <= '0;
            r_recent  <= '0;
            r_pos     <= '0;
            r_ph      <= '0;
            r_i       <= '0;
            r_is_load <= 1'b0;
            r_ov      <= 1'b0;
            r_cvq     <= 1'b0;
            for (int k = 0; k < MAX_WORD_LEN; k++) begin
                r_mod[k]  <= '0;
                r_head[k] <= '0;
                r_fill[k] <= '0;
            end
            for (int j = 0; j < CDEPTH; j++) r_cval[j] <= 1'b0;
        end else begin
            r_cvq <= r_cval[c_raddr];
            if (i_cfg_we) r_wlen <= i_cfg_wdata;
            if (i_ctl.push && n_fill == r_total) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end

            if (i_ctl.accept) begin
                r_i       <= '0;
                r_is_load <= (s_cmd == wmwm_pkg::CMD_LOAD);
                case (s_cmd)
                    wmwm_pkg::CMD_LOAD: begin
                        r_key <= s_word & w_mask;
                        if (load_ok && r_used == '0) begin
                            r_used  <= CW'(1);
                            r_total <= r_total + CW'(1);
                        end
                    end
                    wmwm_pkg::CMD_CHAR: begin
                        if (char_ok) begin
                            r_recent <= n_recent;
                            r_pos    <= n_pos;
                            r_ph     <= n_ph;
                            r_key    <= n_cur;
                            for (int k = 0; k < MAX_WORD_LEN; k++) r_mod[k] <= n_mod[k];
                        end
                    end
                    wmwm_pkg::CMD_NEW: begin
                        r_recent <= '0;
                        r_pos    <= '0;
                        r_ph     <= '0;
                        for (int k = 0; k < MAX_WORD_LEN; k++) begin
                            r_mod[k]  <= '0;
                            r_head[k] <= '0;
                            r_fill[k] <= '0;
                        end
                        for (int j = 0; j < CDEPTH; j++) r_cval[j] <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_ctl.cmp) begin
                if (hit) begin
                    if (r_is_load) begin
                        r_total <= r_total + CW'(1);
                    end else begin
                        r_idx <= r_i;
                        r_tgt <= r_dict_q[CW+63:64];
                    end
                end else if (last) begin
                    if (r_is_load) begin
                        r_used  <= r_used + CW'(1);
                        r_total <= r_total + CW'(1);
                    end else begin
                        // unknown word empties this phase's window
                        r_head[r_ph] <= '0;
                        r_fill[r_ph] <= '0;
                        for (int j = 0; j < CDEPTH; j++) begin
                            if (j / MAX_WORDS == int'(r_ph)) r_cval[j] <= 1'b0;
                        end
                    end
                end else begin
                    r_i <= r_i + IW'(1);
                end
            end

            if (i_ctl.cchk) r_cnt <= oc;
            if (i_ctl.hrd) r_old <= r_hist_q;

            if (i_ctl.pop) begin
                if (oc != '0) begin
                    r_cval[c_waddr] <= 1'b1;
                    if (r_old == r_idx) r_cnt <= r_cnt - CW'(1);
                end
                r_head[r_ph] <= n_head;
                r_fill[r_ph] <= cur_fill - CW'(1);
            end

            if (i_ctl.push) begin
                r_cval[c_waddr] <= 1'b1;
                r_fill[r_ph]    <= n_fill;
                if (n_fill == r_total) begin
                    r_od <= start_full[15:0];
                end
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;

endmodule

@@ design/word_multiset_window_match.sv @@
// top level of the word multiset window matcher
//
// Input stream (s side): tuser carries the command (load word, text character,
// new text); tdata carries the word in bits 63:0 and the character in 71:64.
// Output stream (m side): tdata carries the 16-bit start of each full match.
// The word length is written through i_cfg_we / i_cfg_wdata; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// Every beat is handled one at a time. A new text or an ignored beat needs no
// scan. A load or a character scans the stored words in turn until a hit or the
// last word. A hit character then reads its window count (ST_CRD, ST_CCHK),
// drops the oldest word (ST_HRD, ST_ORD) while that count is full, and pushes.
// A match shows on the m side the cycle after the push; within a text, results
// leave in ascending order of start position.
// A synchronous active-low reset empties the dictionary, clears the text state
// and sets the word length to 1. When the receiver stalls with a result still held,
// the push waits; a new beat is still accepted while a result waits.
module word_multiset_window_match #(
    parameter int MAX_WORDS    = wmwm_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = wmwm_pkg::MAX_WORD_LEN_DEF,
    parameter int TEXT_LEN     = wmwm_pkg::TEXT_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [wmwm_pkg::S_DATA_W-1:0] i_s_tdata,  // word[63:0], ch[71:64]
    input  logic [wmwm_pkg::CMD_W-1:0]    i_s_tuser,  // command[1:0]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [wmwm_pkg::M_DATA_W-1:0] o_m_tdata,  // match_start[15:0]
    input  logic                          i_cfg_we,
    input  logic [wmwm_pkg::WLEN_W-1:0]   i_cfg_wdata
);

    wmwm_pkg::t_ctl ctl;
    wmwm_pkg::t_sts sts;

    wmwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    wmwm_datapath #(
        .MAX_WORDS    (MAX_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .TEXT_LEN     (TEXT_LEN)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata)
    );

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push |-> !sts.out_busy)
        else $error("push while result held");

    a_out_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(ctl.push))
        else $error("result without push");

    a_pop_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.hrd |-> (sts.cnt_full && sts.fill_nz))
        else $error("drop without full count");

    a_busy_during_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.cmp || ctl.pop || ctl.push) |-> !o_s_tready)
        else $error("input ready during work");

endmodule

@@ dv/word_multiset_window_match_tb.sv @@
// testbench for word_multiset_window_match: random stream traffic checked against a predictor
module word_multiset_window_match_tb;

    localparam int NWORDS   = 16;
    localparam int TEXT_MAX = 65536;
    localparam int SETTLE   = 200;
    localparam int WD_LIMIT = 5000;

    typedef struct {
        wmwm_pkg::t_cmd cmd;
        logic [63:0]    word;
        logic [7:0]     ch;
    } t_beat;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_valid = 1'b0;
    logic [wmwm_pkg::S_DATA_W-1:0] s_data = '0;
    logic [wmwm_pkg::CMD_W-1:0]    s_user = wmwm_pkg::CMD_NOP;
    logic                          m_ready = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [wmwm_pkg::WLEN_W-1:0]   cfg_wdata = '0;
    logic                          s_ready;
    logic                          m_valid;
    logic [wmwm_pkg::M_DATA_W-1:0] m_data;

    t_beat        pending_beats[$];
    logic [15:0]  expected_starts[$];
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           errors = 0;
    int           quiet_cycles = 0;
    t_beat        nxt;

    // predictor state
    logic [wmwm_pkg::WLEN_W-1:0] p_wlen;
    logic [63:0]       p_words[NWORDS];
    int                p_target[NWORDS];
    int                p_used;
    int                p_total;
    logic [63:0]       p_recent;
    int                p_pos;
    int                p_cnt[8][NWORDS];
    int                p_hist[8][NWORDS];
    int                p_head[8];
    int                p_fill[8];

    word_multiset_window_match dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int eff_len();
        if (p_wlen == 0) return 1;
        if (p_wlen > 8) return 8;
        return int'(p_wlen);
    endfunction

    function automatic int find_word(logic [63:0] wd);
        for (int i = 0; i < p_used; i++)
            if (p_words[i] == wd) return i;
        return -1;
    endfunction

    task automatic clear_window(int ph);
        for (int i = 0; i < NWORDS; i++) p_cnt[ph][i] = 0;
        p_head[ph] = 0;
        p_fill[ph] = 0;
    endtask

    task automatic clear_text();
        p_pos = 0;
        p_recent = '0;
        for (int p = 0; p < 8; p++) clear_window(p);
    endtask

    task automatic match_predict(wmwm_pkg::t_cmd c, logic [63:0] wd_in, logic [7:0] chv);
        int w, ph, idx, pos, old, slot;
        logic [63:0] wd, cur;
        w = eff_len();
        if (c == wmwm_pkg::CMD_LOAD) begin
            wd = (w >= 8) ? wd_in : wd_in & ((64'd1 << (8 * w)) - 1);
            if (p_total < NWORDS) begin
                idx = find_word(wd);
                if (idx < 0) begin
                    idx = p_used;
                    p_words[idx] = wd;
                    p_target[idx] = 0;
                    p_used++;
                end
                p_target[idx]++;
                p_total++;
            end
        end else if (c == wmwm_pkg::CMD_NEW) begin
            clear_text();
        end else if (c == wmwm_pkg::CMD_CHAR && p_pos < TEXT_MAX) begin
            p_recent = {chv, p_recent[63:8]};
            pos = p_pos;
            p_pos++;
            if (pos + 1 >= w && p_total != 0) begin
                ph = (pos + 1) % w;
                cur = (w >= 8) ? p_recent : p_recent >> (64 - 8 * w);
                idx = find_word(cur);
                if (idx < 0) begin
                    clear_window(ph);
                end else begin
                    while (p_cnt[ph][idx] >= p_target[idx] && p_fill[ph] > 0) begin
                        old = p_hist[ph][p_head[ph]];
                        if (p_cnt[ph][old] > 0) p_cnt[ph][old]--;
                        p_head[ph] = (p_head[ph] + 1) % NWORDS;
                        p_fill[ph]--;
                    end
                    if (p_cnt[ph][idx] < p_target[idx]) begin
                        slot = (p_head[ph] + p_fill[ph]) % NWORDS;
                        p_hist[ph][slot] = idx;
                        p_fill[ph]++;
                        p_cnt[ph][idx]++;
                        if (p_fill[ph] == p_total)
                            expected_starts = {expected_starts,
                                               16'(pos + 1 - w * p_fill[ph])};
                    end
                end
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_beats.pop_front();
                s_valid <= 1'b1;
                s_data <= {nxt.ch, nxt.word};
                s_user <= nxt.cmd;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: check results first, then predict from the accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                if (expected_starts.size() == 0) begin
                    $error("unexpected match_start actual %0d", m_data);
                    errors++;
                end else if (expected_starts[0] != m_data) begin
                    $error("match_start expected %0d actual %0d", expected_starts[0], m_data);
                    errors++;
                    void'(expected_starts.pop_front());
                end else begin
                    void'(expected_starts.pop_front());
                end
            end
            if (s_valid && s_ready)
                match_predict(wmwm_pkg::t_cmd'(s_user), s_data[63:0], s_data[71:64]);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WD_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_beat(wmwm_pkg::t_cmd c, logic [63:0] wd, logic [7:0] chv);
        t_beat b;
        b.cmd = c;
        b.word = wd;
        b.ch = chv;
        pending_beats = {pending_beats, b};
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_beat(wmwm_pkg::CMD_CHAR, {$urandom, $urandom}, s[i]);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || s_valid || expected_starts.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_wlen(logic [wmwm_pkg::WLEN_W-1:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        p_wlen = v;
        cfg_we <= 1'b0;
    endtask

    task automatic add_dict_word(int idx, int w, ref int n);
        for (int b = 0; b < w; b++) begin
            add_beat(wmwm_pkg::CMD_CHAR, {$urandom, $urandom}, p_words[idx][8 * b +: 8]);
            n++;
        end
    endtask

    // mostly whole concatenations in random order, plus loose words and noise
    task automatic gen_text(int count);
        int n, r, w, k, t, cut;
        int order[$];
        n = 0;
        w = eff_len();
        add_beat(wmwm_pkg::CMD_NEW, '0, '0);
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 70 && p_used > 0) begin
                order.delete();
                for (int i = 0; i < p_used; i++)
                    for (int j = 0; j < p_target[i]; j++) order = {order, i};
                for (int i = order.size() - 1; i > 0; i--) begin
                    k = $urandom_range(i);
                    t = order[i];
                    order[i] = order[k];
                    order[k] = t;
                end
                cut = (r < 64) ? order.size() : $urandom_range(order.size());
                for (int i = 0; i < cut; i++) add_dict_word(order[i], w, n);
            end else if (r < 82 && p_used > 0) begin
                add_dict_word($urandom_range(p_used - 1), w, n);
            end else if (r < 95) begin
                add_beat(wmwm_pkg::CMD_CHAR, {$urandom, $urandom}, 8'($urandom));
                n++;
            end else if (r < 98) begin
                add_beat(wmwm_pkg::CMD_NEW, {$urandom, $urandom}, 8'($urandom));
            end else begin
                add_beat(wmwm_pkg::CMD_NOP, {$urandom, $urandom}, 8'($urandom));
            end
        end
    endtask

    task automatic load_words(int cnt);
        for (int i = 0; i < cnt; i++)
            add_beat(wmwm_pkg::CMD_LOAD, {$urandom, $urandom}, 8'($urandom));
    endtask

    task automatic set_idle(int sp, int rp);
        idle_pct = sp;
        stall_pct = rp;
    endtask

    initial begin
        logic [63:0] wa, wb;
        p_wlen = 4'd1;
        p_used = 0;
        p_total = 0;
        for (int i = 0; i < NWORDS; i++) begin
            p_words[i] = '0;
            p_target[i] = 0;
        end
        clear_text();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty dictionary, unknown command
        add_beat(wmwm_pkg::CMD_NOP, '1, 8'hff);
        add_beat(wmwm_pkg::CMD_NEW, '0, '0);
        for (int i = 0; i < 40; i++)
            add_beat(wmwm_pkg::CMD_CHAR, {$urandom, $urandom}, 8'($urandom));
        add_beat(wmwm_pkg::CMD_NEW, '0, '0);
        drain();

        // word length 0 acts as 1; masking and duplicate targets
        write_wlen(4'd0);
        wa = {$urandom, $urandom};
        wb = {$urandom, $urandom};
        wa[7:0] = "A";
        wb[7:0] = "B";
        add_beat(wmwm_pkg::CMD_LOAD, wa, '0);
        add_beat(wmwm_pkg::CMD_LOAD, wb, '0);
        add_beat(wmwm_pkg::CMD_LOAD, ~wa & 64'hffff_ffff_ffff_ff00 | 64'h41, '0);
        drain();
        add_beat(wmwm_pkg::CMD_NEW, '0, '0);
        add_text("AABABAABAACBAAAB");
        add_beat(wmwm_pkg::CMD_NEW, '0, '0);
        add_text("BAA");
        drain();
        gen_text(260);
        drain();

        write_wlen(4'd3);
        set_idle(47, 0);
        load_words(4);
        add_beat(wmwm_pkg::CMD_LOAD,
                 {$urandom, $urandom} & 64'hffff_ffff_ff00_0000 | p_words[0], '0);
        drain();
        gen_text(400);
        drain();

        write_wlen(4'd8);
        set_idle(0, 47);
        load_words(4);
        drain();
        gen_text(400);
        drain();

        // fills the dictionary, the last load is dropped
        write_wlen(4'd15);
        set_idle(17, 17);
        load_words(5);
        drain();
        gen_text(400);
        drain();

        write_wlen(4'd1);
        set_idle(0, 0);
        gen_text(150);
        drain();
        write_wlen(4'd2);
        set_idle(17, 17);
        gen_text(150);
        drain();

        if (errors == 0 && expected_starts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
